// ===== hw/rtl/bbr_pkg.sv =====
// shared constants, types and helpers for the block byte reverser
`timescale 1ns / 1ps

package bbr_pkg;

  localparam int MAX_BLOCK = 64;
  localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
  localparam int REG_W     = 7;
  localparam int IDX_W     = 2;
  localparam int BYTE_W    = 8;
  localparam int TOP_BIT   = 7;

  localparam logic [IDX_W-1:0] REG_MIN_BLOCK = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_MAX_BLOCK = IDX_W'(1);

  localparam logic [REG_W-1:0] MIN_BLOCK_RST = REG_W'(2);
  localparam logic [REG_W-1:0] MAX_BLOCK_RST = REG_W'(8);

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctl_t;

  // zero acts as one, anything above the store depth saturates
  function automatic logic [CNT_W-1:0] eff_len(input logic [REG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > MAX_BLOCK) begin
      r = CNT_W'(MAX_BLOCK);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bbr_in_if.sv =====
// input channel: one raw byte per request
`timescale 1ns / 1ps

interface bbr_in_if;
  import bbr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t in_byte;
  logic  end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

// ===== hw/rtl/bbr_out_if.sv =====
// output channel: one transformed byte per request
`timescale 1ns / 1ps

interface bbr_out_if;
  import bbr_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  run_end;
  logic  stream_done;

  modport source (output valid, output out_byte, output run_end, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input stream_done,
                  output ready);
endinterface

// ===== hw/rtl/varying_block_byte_reverser_core.sv =====
// Block byte reverser: header pass-through, then growing blocks emitted in reverse.
//
// Channels: in_ch takes one byte per request with an end-of-stream flag, out_ch
// gives one byte per request with run_end on the last byte an input causes and
// stream_done on the final byte of the stream. cfg_wr/cfg_index/cfg_data write
// min_block (index 0) and max_block (index 1); other indexes are ignored.
// Header bytes come out in the cycle after acceptance, one per cycle unless out_ch
// stalls. Body bytes are pushed into a stack of MAX_BLOCK byte cells at one per
// cycle unless out_ch stalls; a full block (or stream end) is then popped from
// the top one byte per cycle unless out_ch stalls; in_ch is held off meanwhile.
// A request is taken in the same cycle the output register hands its result on.
// Reset (synchronous) returns to header mode with min_block 2, max_block 8 and
// an empty stack; no clearing pass is needed. When out_ch stalls, the pending
// result holds and the drain pauses; in_ch is held off until the slot frees.
`timescale 1ns / 1ps

module varying_block_byte_reverser_core (
  input  logic                      clk,
  input  logic                      rst,
  bbr_in_if.sink                    in_ch,
  bbr_out_if.source                 out_ch,
  input  logic                      cfg_wr,
  input  logic [bbr_pkg::IDX_W-1:0] cfg_index,
  input  logic [bbr_pkg::REG_W-1:0] cfg_data
);
  import bbr_pkg::*;

  logic [REG_W-1:0] min_block;
  logic [REG_W-1:0] max_block;
  logic             header_passed;
  logic [CNT_W-1:0] block_size;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] remain;
  logic             eos_flag;

  logic             out_valid;
  byte_t            out_byte;
  logic             out_run_end;
  logic             out_done;

  logic             out_free;
  logic             in_take;
  logic             body_take;
  logic             pop;
  logic [CNT_W-1:0] size;
  logic [CNT_W-1:0] fill_next;
  logic             block_end;
  byte_t            top;
  stack_ctl_t       ctl;

  assign out_free  = !out_valid || out_ch.ready;
  assign in_ch.ready = out_free && (remain == '0);
  assign in_take   = in_ch.valid && in_ch.ready;
  assign body_take = in_take && header_passed;
  assign pop       = (remain != '0) && out_free;

  // block_size only ever holds an effective length
  assign size      = block_size;
  assign fill_next = fill_count + CNT_W'(1);
  assign block_end = (fill_next >= size) || in_ch.end_of_stream;

  assign ctl.push = body_take;
  assign ctl.pop  = pop;

  bbr_cell_row u_row (
    .clk (clk),
    .ctl (ctl),
    .din (in_ch.in_byte),
    .top (top)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_block <= MIN_BLOCK_RST;
      max_block <= MAX_BLOCK_RST;
    end else if (cfg_wr) begin
      if (cfg_index == REG_MIN_BLOCK) begin
        min_block <= cfg_data;
      end else if (cfg_index == REG_MAX_BLOCK) begin
        max_block <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_passed <= 1'b0;
      block_size    <= eff_len(MIN_BLOCK_RST);
      fill_count    <= '0;
      remain        <= '0;
      eos_flag      <= 1'b0;
    end else begin
      if (pop) begin
        remain <= remain - CNT_W'(1);
      end
      if (in_take && !header_passed) begin
        if (!in_ch.in_byte[TOP_BIT] && !in_ch.end_of_stream) begin
          header_passed <= 1'b1;
          block_size    <= eff_len(min_block);
        end
        fill_count <= '0;
      end else if (body_take) begin
        if (block_end) begin
          remain     <= fill_next;
          eos_flag   <= in_ch.end_of_stream;
          fill_count <= '0;
          if (size >= eff_len(max_block)) begin
            block_size <= eff_len(min_block);
          end else begin
            block_size <= size + CNT_W'(1);
          end
          if (in_ch.end_of_stream) begin
            header_passed <= 1'b0;
          end
        end else begin
          fill_count <= fill_next;
        end
      end
    end
  end

  // output register: header byte straight through, or the stack top while draining
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && !header_passed) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && !header_passed) begin
      out_byte    <= in_ch.in_byte;
      out_run_end <= 1'b1;
      out_done    <= in_ch.end_of_stream;
    end else if (pop) begin
      out_byte    <= top;
      out_run_end <= (remain == CNT_W'(1));
      out_done    <= eos_flag && (remain == CNT_W'(1));
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.run_end     = out_run_end;
  assign out_ch.stream_done = out_done;

  a_no_push_pop: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.pop))
    else $error("stack pushed and popped in the same cycle");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (remain != '0) |-> !in_ch.ready)
    else $error("input taken while a block drains");

  a_fill_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(fill_count) < MAX_BLOCK)
    else $error("fill count beyond stack depth");

  a_last_pop_marks_end: assert property (@(posedge clk) disable iff (rst)
    (pop && remain == CNT_W'(1)) |=> (out_ch.valid && out_ch.run_end))
    else $error("last drained byte not marked as run end");

endmodule

// ===== hw/rtl/bbr_cell.sv =====
// one byte cell of the reversal stack
`timescale 1ns / 1ps

module bbr_cell (
  input  logic               clk,
  input  bbr_pkg::stack_ctl_t ctl,
  input  bbr_pkg::byte_t      push_data,
  input  bbr_pkg::byte_t      pop_data,
  output bbr_pkg::byte_t      q
);
  import bbr_pkg::*;

  // push takes the neighbour nearer the top, pop takes the one further down
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      q <= push_data;
    end else if (ctl.pop) begin
      q <= pop_data;
    end
  end

endmodule

// ===== hw/rtl/bbr_cell_row.sv =====
// row of cells forming a last-in first-out byte stack
`timescale 1ns / 1ps

module bbr_cell_row (
  input  logic               clk,
  input  bbr_pkg::stack_ctl_t ctl,
  input  bbr_pkg::byte_t      din,
  output bbr_pkg::byte_t      top
);
  import bbr_pkg::*;

  byte_t q [MAX_BLOCK];

  for (genvar i = 0; i < MAX_BLOCK; i++) begin : g_cell
    byte_t up_data;
    byte_t dn_data;

    if (i == 0) begin : g_first
      assign up_data = din;
    end else begin : g_mid
      assign up_data = q[i-1];
    end

    if (i == MAX_BLOCK - 1) begin : g_last
      assign dn_data = '0;
    end else begin : g_inner
      assign dn_data = q[i+1];
    end

    bbr_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .push_data (up_data),
      .pop_data  (dn_data),
      .q         (q[i])
    );
  end

  assign top = q[0];

endmodule

// ===== dv/bbr_reversal_checker.sv =====
// checker for the block byte reverser: predicts each output byte and compares it
`timescale 1ns / 1ps

module bbr_reversal_checker (
  input  logic                      clk,
  input  logic                      rst,
  bbr_in_if                         in_mon,
  bbr_out_if                        out_mon,
  input  logic                      cfg_wr,
  input  logic [bbr_pkg::IDX_W-1:0] cfg_index,
  input  logic [bbr_pkg::REG_W-1:0] cfg_data,
  output int                        errors,
  output int                        outstanding
);
  import bbr_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  run_end;
    logic  stream_done;
  } rev_byte_t;

  rev_byte_t        expected_bytes[$];
  logic [REG_W-1:0] min_reg;
  logic [REG_W-1:0] max_reg;
  logic             in_body;
  int               blk_len;
  int               fill;
  byte_t            blk_store [MAX_BLOCK];
  int               err_cnt;

  function automatic int clamp_len(input logic [REG_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_BLOCK) return MAX_BLOCK;
    return int'(v);
  endfunction

  function automatic void push_result(input byte_t d, input logic re, input logic sd);
    rev_byte_t r;
    r.data        = d;
    r.run_end     = re;
    r.stream_done = sd;
    expected_bytes.push_back(r);
  endfunction

  function automatic void predict_reversal(input byte_t b, input logic eos);
    int size;
    if (!in_body) begin
      push_result(b, 1'b1, eos);
      // first byte with top bit clear closes the header
      if (!b[TOP_BIT]) begin
        in_body = 1'b1;
        blk_len = clamp_len(min_reg);
        fill    = 0;
      end
      if (eos) begin
        in_body = 1'b0;
        fill    = 0;
      end
    end else begin
      size = blk_len;
      if (fill >= MAX_BLOCK) fill = 0;
      blk_store[fill] = b;
      fill++;
      if (fill >= size || eos) begin
        for (int k = fill - 1; k >= 0; k--) begin
          push_result(blk_store[k], k == 0, eos && (k == 0));
        end
        fill    = 0;
        blk_len = (size >= clamp_len(max_reg)) ? clamp_len(min_reg) : size + 1;
        if (eos) in_body = 1'b0;
      end
    end
  endfunction

  always @(posedge clk) begin
    rev_byte_t want;
    if (rst) begin
      min_reg = MIN_BLOCK_RST;
      max_reg = MAX_BLOCK_RST;
      in_body = 1'b0;
      blk_len = clamp_len(MIN_BLOCK_RST);
      fill    = 0;
      err_cnt = 0;
      expected_bytes.delete();
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_MIN_BLOCK: min_reg = cfg_data;
          REG_MAX_BLOCK: max_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        predict_reversal(in_mon.in_byte, in_mon.end_of_stream);
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected output: expected nothing, got byte %02h run_end %0b %s %0b",
                   $time, out_mon.out_byte, out_mon.run_end, "stream_done",
                   out_mon.stream_done);
        end else begin
          want = expected_bytes.pop_front();
          if (out_mon.out_byte !== want.data || out_mon.run_end !== want.run_end ||
              out_mon.stream_done !== want.stream_done) begin
            err_cnt++;
            $display("%0t: mismatch: expected byte %02h run_end %0b stream_done %0b,",
                     $time, want.data, want.run_end, want.stream_done);
            $display("%0t:           got byte %02h run_end %0b stream_done %0b",
                     $time, out_mon.out_byte, out_mon.run_end, out_mon.stream_done);
          end
        end
      end
    end
    errors      <= err_cnt;
    outstanding <= expected_bytes.size();
  end

endmodule

// ===== dv/varying_block_byte_reverser_core_test.sv =====
// top of the block byte reverser testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module varying_block_byte_reverser_core_test;
  import bbr_pkg::*;

  localparam int ITEM_TARGET = 420;
  localparam int PHASE_ITEMS = 30;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 12;
  localparam int END_WAIT    = 20;
  localparam int LONG_HOLD   = 300;

  localparam logic [IDX_W-1:0] REG_UNUSED_A = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_UNUSED_B = IDX_W'(3);

  logic             clk;
  logic             rst;
  logic             cfg_wr;
  logic [IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;
  int               err_total;
  int               pending_bytes;
  int               items_sent;
  int               cycles = 0;
  logic             sender_calm;

  bbr_in_if  in_ch ();
  bbr_out_if out_ch ();

  varying_block_byte_reverser_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bbr_reversal_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_wr      (cfg_wr),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (err_total),
    .outstanding (pending_bytes)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (sender_calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input byte_t b, input logic eos);
    int   gap;
    logic taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.end_of_stream <= eos;
    // ready only moves just after a rising edge, so sample it mid-cycle
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end
    items_sent++;
  endtask

  // header of bytes with the top bit set, a closing byte, then a body
  task automatic send_stream(input logic finish);
    int    hdr_n;
    int    body_n;
    logic  brk;
    byte_t b;
    hdr_n  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
    body_n = ($urandom_range(0, 5) == 0) ? $urandom_range(31, 140) : $urandom_range(0, 30);
    for (int i = 0; i < hdr_n; i++) begin
      brk = finish && ($urandom_range(0, 9) == 0);
      b = BYTE_W'($urandom_range(0, 255));
      b[TOP_BIT] = 1'b1;
      send_byte(b, brk);
      if (brk) return;
    end
    b = BYTE_W'($urandom_range(0, 255));
    b[TOP_BIT] = 1'b0;
    send_byte(b, finish && (body_n == 0));
    for (int i = 0; i < body_n; i++) begin
      b = BYTE_W'($urandom_range(0, 255));
      send_byte(b, finish && (i == body_n - 1));
    end
  endtask

  // stop offering, let every expected byte arrive and the block settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_regs(input logic [REG_W-1:0] mn, input logic [REG_W-1:0] mx,
                            input logic spare);
    cfg_wr    <= 1'b1;
    cfg_index <= REG_MIN_BLOCK;
    cfg_data  <= mn;
    @(posedge clk);
    cfg_index <= REG_MAX_BLOCK;
    cfg_data  <= mx;
    @(posedge clk);
    if (spare) begin
      cfg_index <= REG_UNUSED_A;
      cfg_data  <= REG_W'($urandom_range(0, 127));
      @(posedge clk);
      cfg_index <= REG_UNUSED_B;
      cfg_data  <= REG_W'($urandom_range(0, 127));
      @(posedge clk);
    end
    cfg_wr <= 1'b0;
  endtask

  // receiver: random ready pattern with one long hold-off
  initial begin
    int iter;
    int hold_at;
    int r;
    int n;
    out_ch.ready <= 1'b0;
    iter    = 0;
    hold_at = $urandom_range(20, 60);
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      iter++;
      r = $urandom_range(0, 99);
      if (iter == hold_at) begin
        out_ch.ready <= 1'b0;
        n = LONG_HOLD;
      end else if (r < 45) begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(1, 12);
      end else if (r < 55) begin
        out_ch.ready <= 1'b1;
        n = $urandom_range(30, 80);
      end else if (r < 88) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 3);
      end else begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(8, 40);
      end
      repeat (n) @(posedge clk);
    end
  end

  initial begin
    int               ph;
    int               rand_start;
    int               phase_start;
    logic [REG_W-1:0] mn;
    logic [REG_W-1:0] mx;
    items_sent          = 0;
    sender_calm         = 1'b0;
    rst                 <= 1'b1;
    cfg_wr              <= 1'b0;
    cfg_index           <= REG_MIN_BLOCK;
    cfg_data            <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= '0;
    in_ch.end_of_stream <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset lengths 2..8: header, blocks of 2 and 3, partial block at stream end
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    // stream end on a header byte, and on the closing header byte
    send_byte(8'h80, 1'b1);
    send_byte(8'h00, 1'b1);
    // one-byte body ended by stream end
    send_byte(8'h00, 1'b0);
    send_byte(8'h11, 1'b1);
    // block filling up on the very byte that ends the stream
    send_byte(8'h7F, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b1);

    ph = 0;
    rand_start = items_sent;
    while (items_sent - rand_start < ITEM_TARGET) begin
      wait_idle();
      case (ph)
        0: begin mn = REG_W'(1);   mx = REG_W'(1);   end
        1: begin mn = REG_W'(0);   mx = REG_W'(0);   end
        2: begin mn = REG_W'(64);  mx = REG_W'(64);  end
        3: begin mn = REG_W'(127); mx = REG_W'(100); end
        4: begin mn = REG_W'(1);   mx = REG_W'(64);  end
        5: begin mn = REG_W'(10);  mx = REG_W'(3);   end
        6: begin mn = REG_W'(5);   mx = REG_W'(5);   end
        7: begin mn = REG_W'(3);   mx = REG_W'(6);   end
        8: begin mn = REG_W'(0);   mx = REG_W'(127); end
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            mn = REG_W'($urandom_range(0, 127));
            mx = REG_W'($urandom_range(0, 127));
          end else begin
            mn = REG_W'($urandom_range(1, 6));
            mx = REG_W'($urandom_range(1, 10));
          end
        end
      endcase
      write_regs(mn, mx, (ph == 1) || ($urandom_range(0, 2) == 0));
      sender_calm = ($urandom_range(0, 3) == 0);
      phase_start = items_sent;
      // unfinished streams leave the block mid-body across a register change
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_stream($urandom_range(0, 3) != 0);
      end
      ph++;
    end
    sender_calm = 1'b0;
    send_stream(1'b1);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (err_total == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
